// File: rtl/wsh32_pkg.sv
// Package for the 32-bit word stream hash.
// Holds the hash constants, the datapath command type and the byte count helper.
// Used by wsh32_ctrl, wsh32_dp and word_stream_hash_32.
package wsh32_pkg;

  localparam logic [31:0] INIT_XOR = 32'h971e137b;
  localparam logic [31:0] M1_INIT  = 32'h95543787;
  localparam logic [31:0] M2_INIT  = 32'h2ad7eb25;
  localparam logic [31:0] H_ADD    = 32'ha6b84e31;
  localparam logic [31:0] M1_ADD   = 32'h273581d8;
  localparam logic [31:0] M2_ADD   = 32'hee700bac;
  localparam logic [31:0] FIN_MUL1 = 32'h85ebca6b;
  localparam logic [31:0] FIN_MUL2 = 32'hc2b2ae35;

  localparam logic [2:0] FULL_COUNT = 3'd4;

  typedef enum logic [1:0] {
    MS_WORD,
    MS_ROT,
    MS_FIN1,
    MS_FIN2
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     init;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     mix;
    logic     advance;
    logic     load_out;
  } dp_cmd_t;

  function automatic logic [2:0] eff_count(logic [2:0] cnt, logic last);
    logic [2:0] res;
    if (!last || cnt[2]) begin
      res = FULL_COUNT;
    end else begin
      res = cnt;
    end
    return res;
  endfunction

endpackage

// File: rtl/wsh32_ctrl.sv
// Controller of the 32-bit word stream hash.
// Sequences word mixing and finalisation and owns the handshake state.
// Depends on wsh32_pkg.
module wsh32_ctrl import wsh32_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] byte_count_i,
  input  logic       last_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL2 = 3'd1;
  localparam logic [2:0] ST_MIX  = 3'd2;
  localparam logic [2:0] ST_FIN1 = 3'd3;
  localparam logic [2:0] ST_FIN2 = 3'd4;
  localparam logic [2:0] ST_FIN3 = 3'd5;

  logic [2:0] state_q, state_d;
  logic       mid_q, mid_d;
  logic       last_q, last_d;
  logic       full_q, full_d;
  logic       out_valid_q, out_valid_d;
  logic [2:0] eff;

  assign eff = eff_count(byte_count_i, last_word_i);

  always_comb begin
    state_d = state_q;
    mid_d   = mid_q;
    last_d  = last_q;
    full_d  = full_q;
    cmd_o   = '{default: '0, mul_sel: MS_WORD};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.init    = !mid_q;
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MS_WORD;
          last_d        = last_word_i;
          full_d        = (eff == FULL_COUNT);
          mid_d         = !last_word_i;
          state_d       = (eff == 3'd0) ? ST_FIN1 : ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_ROT;
        state_d       = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mix     = 1'b1;
        cmd_o.advance = full_q;
        state_d       = last_q ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_FIN1;
        state_d       = ST_FIN2;
      end
      ST_FIN2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_FIN2;
        state_d       = ST_FIN3;
      end
      ST_FIN3: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || cmd_o.load_out;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mid_q       <= 1'b0;
      last_q      <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mid_q       <= mid_d;
      last_q      <= last_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_fin_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN1 |=> state_q == ST_FIN2)
    else $error("finalisation steps out of order");

  a_mix_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && in_valid_i && eff != 3'd0 |=> state_q == ST_MUL2)
    else $error("word transfer not followed by second multiply");

  a_mid_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MIX && !last_q |=> state_q == ST_IDLE && mid_q)
    else $error("inner word did not return to idle mid-message");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("pending result overwritten");

endmodule

// File: rtl/wsh32_dp.sv
// Datapath of the 32-bit word stream hash.
// Holds the seed, running hash, multipliers, byte total and one shared multiplier.
// Depends on wsh32_pkg; driven by wsh32_ctrl commands.
module wsh32_dp import wsh32_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_word_i,
  output logic [31:0] hash_value_o
);

  logic [31:0] seed_q;
  logic [31:0] h_q, h_d;
  logic [31:0] m1_q, m1_d;
  logic [31:0] m2_q, m2_d;
  logic [31:0] total_q, total_d;
  logic [31:0] p_q, p_d;
  logic [31:0] hash_q, hash_d;
  logic [2:0]  eff;
  logic [31:0] mask;
  logic [31:0] m1_cur;
  logic [31:0] hx;
  logic [31:0] op_a, op_b, prod;

  assign eff = eff_count(byte_count_i, last_word_i);

  always_comb begin
    case (eff)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign m1_cur = cmd_i.init ? M1_INIT : m1_q;
  assign hx     = h_q ^ total_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MS_WORD: begin
        op_a = data_word_i & mask;
        op_b = m1_cur;
      end
      MS_ROT: begin
        op_a = {p_q[20:0], p_q[31:21]};
        op_b = m2_q;
      end
      MS_FIN1: begin
        op_a = hx ^ (hx >> 16);
        op_b = FIN_MUL1;
      end
      MS_FIN2: begin
        op_a = p_q ^ (p_q >> 13);
        op_b = FIN_MUL2;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_comb begin
    h_d     = h_q;
    m1_d    = m1_q;
    m2_d    = m2_q;
    total_d = total_q;
    p_d     = cmd_i.mul_en ? prod : p_q;
    hash_d  = cmd_i.load_out ? (p_q ^ (p_q >> 16)) : hash_q;
    if (cmd_i.load) begin
      if (cmd_i.init) begin
        h_d     = seed_q ^ INIT_XOR;
        m1_d    = M1_INIT;
        m2_d    = M2_INIT;
        total_d = {29'd0, eff};
      end else begin
        total_d = total_q + {29'd0, eff};
      end
    end
    if (cmd_i.mix) begin
      h_d = ((h_q << 2) + h_q + H_ADD) ^ p_q;
    end
    if (cmd_i.advance) begin
      m1_d = (m1_q << 3) + m1_q + M1_ADD;
      m2_d = (m2_q << 2) + m2_q + M2_ADD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    m1_q    <= m1_d;
    m2_q    <= m2_d;
    total_q <= total_d;
    p_q     <= p_d;
    hash_q  <= hash_d;
  end

  assign hash_value_o = hash_q;

endmodule

// File: rtl/word_stream_hash_32.sv
// Top level of the 32-bit word stream hash.
// Joins the controller wsh32_ctrl and the datapath wsh32_dp; depends on wsh32_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries data_word_i, byte_count_i and
//   last_word_i; a transfer completes when valid is high and stall is low.
//   Output channel (out_valid_o / out_stall_i) carries hash_value_o, one result
//   per message, after its last word.
//   The user must write the seed through cfg_we_i / cfg_wdata_i only while the
//   block is idle; the block itself does not enforce this. The seed applies from
//   the first word of the next message.
//   A word that carries bytes uses the shared 32x32 multiplier twice, then the hash
//   is updated; the input stalls meanwhile, so no new word is taken before then.
//   A last word with no bytes goes straight to finalisation; finalisation uses the
//   multiplier twice more and then loads the result into the output register.
//   A finished result waits in the output register while the receiver stalls;
//   the next message's words are taken meanwhile, and only the following
//   result waits for the register to drain.
//   Reset clears the seed to zero, drops any pending result and starts a
//   fresh message.
module word_stream_hash_32 import wsh32_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  dp_cmd_t cmd;

  wsh32_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd)
  );

  wsh32_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .hash_value_o (hash_value_o)
  );

endmodule

// File: verif/tb_word_stream_hash_32.sv
`timescale 1ns / 100ps
// Self-checking testbench for word_stream_hash_32: streams messages and compares each hash.
// Depends only on the RTL of word_stream_hash_32 and its package wsh32_pkg.
module tb_word_stream_hash_32;

  localparam logic [31:0] START_XOR  = 32'h971e137b;
  localparam logic [31:0] MULA_START = 32'h95543787;
  localparam logic [31:0] MULB_START = 32'h2ad7eb25;
  localparam logic [31:0] HASH_ADD   = 32'ha6b84e31;
  localparam logic [31:0] MULA_ADD   = 32'h273581d8;
  localparam logic [31:0] MULB_ADD   = 32'hee700bac;
  localparam logic [31:0] FMIX_MUL1  = 32'h85ebca6b;
  localparam logic [31:0] FMIX_MUL2  = 32'hc2b2ae35;
  localparam logic [2:0]  FULL_WORD  = 3'd4;
  localparam int          SETTLE_CYC = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] data_word_i;
  logic [2:0]  byte_count_i;
  logic        last_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] hash_value_o;

  logic [31:0] seed_reg;
  logic [31:0] hash_acc;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] byte_sum;
  logic        in_message;
  logic [31:0] expected_hashes[$];
  logic [31:0] wanted_hash;
  int          errors;
  int          gap_pct;
  int          stall_pct;

  word_stream_hash_32 u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic predict_hash(input logic [31:0] w, input logic [2:0] c, input logic l);
    logic [31:0] k;
    logic [31:0] h;
    logic [2:0]  n;
    if (!in_message) begin
      hash_acc   = seed_reg ^ START_XOR;
      mul_a      = MULA_START;
      mul_b      = MULB_START;
      byte_sum   = '0;
      in_message = 1'b1;
    end
    n = (!l || c >= FULL_WORD) ? FULL_WORD : c;
    if (n != 3'd0) begin
      k = (n == FULL_WORD) ? w : (w & ((32'h1 << (8 * n)) - 32'h1));
      k = k * mul_a;
      k = {k[20:0], k[31:21]};
      k = k * mul_b;
      hash_acc = (hash_acc * 32'd5 + HASH_ADD) ^ k;
      if (n == FULL_WORD) begin
        mul_a = mul_a * 32'd9 + MULA_ADD;
        mul_b = mul_b * 32'd5 + MULB_ADD;
      end
    end
    byte_sum = byte_sum + 32'(n);
    if (l) begin
      h = hash_acc ^ byte_sum;
      h = h ^ (h >> 16);
      h = h * FMIX_MUL1;
      h = h ^ (h >> 13);
      h = h * FMIX_MUL2;
      h = h ^ (h >> 16);
      hash_acc = h;
      expected_hashes.push_back(h);
      in_message = 1'b0;
    end
  endtask

  // hold the word until the transfer, then predict
  task automatic send_word(input logic [31:0] w, input logic [2:0] c, input logic l);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_word_i  <= w;
    byte_count_i <= c;
    last_word_i  <= l;
    do @(posedge clk_i); while (in_stall_o);
    predict_hash(w, c, l);
  endtask

  task automatic send_message(input int words);
    logic [2:0] c;
    for (int i = 0; i < words; i++) begin
      if (i == words - 1) begin
        c = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
      end else begin
        c = 3'($urandom_range(0, 7));
      end
      send_word($urandom, c, i == words - 1);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    seed_reg = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_single_words();
    for (int c = 0; c < 8; c++) begin
      send_word(32'hffffffff, 3'(c), 1'b1);
    end
    send_word(32'h00000000, FULL_WORD, 1'b1);
    send_word(32'h00000000, 3'd0, 1'b1);
    send_word(32'h80000001, 3'd3, 1'b1);
  endtask

  task automatic test_long_messages();
    send_word(32'hffffffff, 3'd0, 1'b0);
    send_word(32'h00000000, 3'd7, 1'b0);
    send_word(32'h12345678, 3'd1, 1'b0);
    send_word(32'hdeadbeef, 3'd2, 1'b1);
    send_word(32'hffffffff, 3'd3, 1'b0);
    send_word(32'hffffffff, 3'd0, 1'b1);
    send_message(5);
  endtask

  task automatic test_seeds();
    logic [31:0] seeds[4];
    seeds = '{32'hffffffff, 32'h00000000, 32'haaaaaaaa, 32'h55555555};
    foreach (seeds[i]) begin
      drain();
      write_seed(seeds[i]);
      send_word(32'ha5a5a5a5, FULL_WORD, 1'b0);
      send_word(32'h5a5a5a5a, 3'd2, 1'b1);
    end
  endtask

  task automatic test_random_stream(input int item_target, input bit vary);
    int left;
    int n;
    left = item_target;
    while (left > 0) begin
      n = $urandom_range(1, 12);
      if (n > left) n = left;
      if (vary && $urandom_range(0, 5) == 0) begin
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
      end
      if (vary && $urandom_range(0, 14) == 0) begin
        drain();
        write_seed($urandom);
      end
      send_message(n);
      left -= n;
    end
  endtask

  task automatic test_back_to_back();
    gap_pct   = 0;
    stall_pct = 0;
    test_random_stream(100, 1'b0);
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    data_word_i  = '0;
    byte_count_i = '0;
    last_word_i  = 1'b0;
    out_stall_i  = 1'b0;
    seed_reg     = '0;
    hash_acc     = '0;
    mul_a        = MULA_START;
    mul_b        = MULB_START;
    byte_sum     = '0;
    in_message   = 1'b0;
    errors       = 0;
    gap_pct      = 20;
    stall_pct    = 20;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_words();
    test_long_messages();
    test_seeds();
    test_random_stream(700, 1'b1);
    drain();
    test_back_to_back();
    in_valid_i <= 1'b0;
    for (int i = 0; i < 5000 && expected_hashes.size() != 0; i++) @(posedge clk_i);
    if (expected_hashes.size() != 0) begin
      report_mismatch($sformatf("%0d hashes never arrived", expected_hashes.size()));
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch($sformatf("hash %h with none expected", hash_value_o));
      end else begin
        wanted_hash = expected_hashes.pop_front();
        if (hash_value_o !== wanted_hash) begin
          report_mismatch($sformatf("hash_value %h, expected %h", hash_value_o, wanted_hash));
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
